// ===== hdl/wrms_pkg.sv =====
// shared widths, register codes and reset values for the windowed rms current meter
package wrms_pkg;

  localparam int unsigned MV_W   = 13;
  localparam int unsigned ADC_W  = 12;
  localparam int unsigned MPA_W  = 10;
  localparam int unsigned MA_W   = 16;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned SQ_W   = 2 * MV_W;
  localparam int unsigned ROOT_W = SUM_W / 2;
  localparam int unsigned PROD_W = ROOT_W + MPA_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MPA_W-1:0] MA_PER_A = MPA_W'(1000);
  localparam logic [MA_W-1:0]  MA_MAX   = '1;
  localparam logic [SUM_W-1:0] SUM_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_POINT = 3'd0,
    CFG_BAND_LOW   = 3'd1,
    CFG_BAND_HIGH  = 3'd2,
    CFG_MV_PER_AMP = 3'd3,
    CFG_FLOOR      = 3'd4,
    CFG_CHANGE     = 3'd5
  } cfg_idx_e;

  localparam logic [MV_W-1:0]  RST_ZERO_POINT = MV_W'(2500);
  localparam logic [MV_W-1:0]  RST_BAND_LOW   = MV_W'(150);
  localparam logic [MV_W-1:0]  RST_BAND_HIGH  = MV_W'(1500);
  localparam logic [MPA_W-1:0] RST_MV_PER_AMP = MPA_W'(185);
  localparam logic [MA_W-1:0]  RST_FLOOR      = MA_W'(400);
  localparam logic [MA_W-1:0]  RST_CHANGE     = MA_W'(500);

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

// ===== hdl/wrms_div.sv =====
// iterative restoring divider, one quotient bit per cycle, shared by mean and scaling
module wrms_div #(
  parameter int unsigned DW = 40,
  parameter int unsigned VW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? diff[VW-1:0] : shifted[VW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/wrms_sqrt.sv =====
// iterative floor square root, one root bit per cycle
module wrms_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrms_pkg::unit_ctl_t           ctl_i,
  input  logic [wrms_pkg::SUM_W-1:0]    radicand_i,
  output logic                          done_o,
  output logic [wrms_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned RW = wrms_pkg::ROOT_W;
  localparam int unsigned SW = wrms_pkg::SUM_W;
  localparam int unsigned MW = RW + 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] rad_q, rad_d;
  logic [RW-1:0] root_q, root_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [MW+1:0] shifted;
  logic [MW+1:0] trial;
  logic [MW+1:0] diff;
  logic          fits;

  assign shifted = {rem_q, rad_q[SW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign fits    = shifted >= trial;
  assign diff    = shifted - trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[SW-3:0], 2'b00};
      root_d = {root_q[RW-2:0], fits};
      rem_d  = fits ? diff[MW-1:0] : shifted[MW-1:0];
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(RW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hdl/windowed_rms_current_meter.sv =====
// top level: sample accumulation, window sequencer and result register
// a sample without window_end holds ready low while ST_ACC adds its in-band square to the sum
// a window_end sample then runs the mean divide, the root, the product and the scaling divide
// before ST_FIN loads the result; ready stays low until the result is loaded
// a new sample is taken only once the square-and-add step of the last one is done
// the result waits in an output register; a new sample is taken while it waits
// reset: asynchronous, active low; registers return to defaults, sum, count and last result clear
module windowed_rms_current_meter #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wrms_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [wrms_pkg::ADC_W-1:0]        adc_mv_i,
  input  logic                              window_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wrms_pkg::MA_W-1:0]         current_ma_o,
  output logic                              changed_o
);

  localparam int unsigned MV_W   = wrms_pkg::MV_W;
  localparam int unsigned MPA_W  = wrms_pkg::MPA_W;
  localparam int unsigned MA_W   = wrms_pkg::MA_W;
  localparam int unsigned SUM_W  = wrms_pkg::SUM_W;
  localparam int unsigned SQ_W   = wrms_pkg::SQ_W;
  localparam int unsigned ROOT_W = wrms_pkg::ROOT_W;
  localparam int unsigned PROD_W = wrms_pkg::PROD_W;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DIV_W  = (CNT_W > MPA_W) ? CNT_W : MPA_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ACC    = 3'd1;
  localparam logic [2:0] ST_MEAN   = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_SCALE0 = 3'd5;
  localparam logic [2:0] ST_SCALE  = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]       state_q, state_d;

  logic [MV_W-1:0]  zero_point_q, band_low_q, band_high_q;
  logic [MPA_W-1:0] mv_per_amp_q;
  logic [MA_W-1:0]  floor_q, change_q;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [MA_W-1:0]  last_q, last_d;

  logic [MV_W-1:0]  dev_q;
  logic             in_band_q;
  logic             end_q;
  logic [PROD_W-1:0] prod_q;

  logic             out_valid_q, out_valid_d;
  logic [MA_W-1:0]  current_q, current_d;
  logic             changed_q, changed_d;

  logic             in_fire;
  logic [MV_W-1:0]  volt;
  logic [MV_W-1:0]  dev;
  logic [SQ_W-1:0]  square;
  logic [SUM_W:0]   sum_add;

  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  wrms_pkg::unit_ctl_t sqrt_ctl;
  logic                sqrt_ctl_done;
  logic [ROOT_W-1:0]   root;

  logic [MA_W-1:0]  sat_ma;
  logic [MA_W-1:0]  cur_ma;
  logic [MA_W-1:0]  diff_ma;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign volt = {adc_mv_i, 1'b0};
  assign dev  = (volt >= zero_point_q) ? volt - zero_point_q : zero_point_q - volt;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_point_q <= wrms_pkg::RST_ZERO_POINT;
      band_low_q   <= wrms_pkg::RST_BAND_LOW;
      band_high_q  <= wrms_pkg::RST_BAND_HIGH;
      mv_per_amp_q <= wrms_pkg::RST_MV_PER_AMP;
      floor_q      <= wrms_pkg::RST_FLOOR;
      change_q     <= wrms_pkg::RST_CHANGE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wrms_pkg::CFG_ZERO_POINT: zero_point_q <= cfg_data_i[MV_W-1:0];
        wrms_pkg::CFG_BAND_LOW:   band_low_q   <= cfg_data_i[MV_W-1:0];
        wrms_pkg::CFG_BAND_HIGH:  band_high_q  <= cfg_data_i[MV_W-1:0];
        wrms_pkg::CFG_MV_PER_AMP: mv_per_amp_q <= cfg_data_i[MPA_W-1:0];
        wrms_pkg::CFG_FLOOR:      floor_q      <= cfg_data_i[MA_W-1:0];
        wrms_pkg::CFG_CHANGE:     change_q     <= cfg_data_i[MA_W-1:0];
        default: ;
      endcase
    end
  end

  // beat capture and scaling product register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dev_q     <= dev;
      in_band_q <= (dev > band_low_q) && (dev < band_high_q);
      end_q     <= window_end_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(root) * PROD_W'(wrms_pkg::MA_PER_A);
    end
  end

  assign square  = in_band_q ? SQ_W'(dev_q) * SQ_W'(dev_q) : '0;
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(square);

  assign div_start    = ((state_q == ST_ACC) && end_q) || (state_q == ST_SCALE0);
  assign div_dividend = (state_q == ST_ACC) ? sum_d : SUM_W'(prod_q);
  always_comb begin
    if (state_q == ST_ACC) begin
      div_divisor = (count_d == '0) ? DIV_W'(1) : DIV_W'(count_d);
    end else begin
      div_divisor = (mv_per_amp_q == '0) ? DIV_W'(1) : DIV_W'(mv_per_amp_q);
    end
  end

  wrms_div #(
    .DW (SUM_W),
    .VW (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_comb begin
    sqrt_ctl.start = (state_q == ST_MEAN) && div_done;
    sqrt_ctl.done  = 1'b0;
  end

  wrms_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sqrt_ctl),
    .radicand_i (div_quotient),
    .done_o     (sqrt_ctl_done),
    .root_o     (root)
  );

  assign sat_ma  = (div_quotient > SUM_W'(wrms_pkg::MA_MAX)) ? wrms_pkg::MA_MAX
                                                             : div_quotient[MA_W-1:0];
  assign cur_ma  = (sat_ma < floor_q) ? '0 : sat_ma;
  assign diff_ma = (cur_ma >= last_q) ? cur_ma - last_q : last_q - cur_ma;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    current_d   = current_q;
    changed_d   = changed_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (count_q < CNT_W'(MAX_SAMPLES)) begin
          sum_d   = sum_add[SUM_W] ? wrms_pkg::SUM_MAX : sum_add[SUM_W-1:0];
          count_d = count_q + CNT_W'(1);
        end
        state_d = end_q ? ST_MEAN : ST_IDLE;
      end
      ST_MEAN: begin
        if (div_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_ctl_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SCALE0;
      end
      ST_SCALE0: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          current_d   = cur_ma;
          changed_d   = diff_ma > change_q;
          last_d      = cur_ma;
          sum_d       = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    current_q <= current_d;
    changed_q <= changed_d;
  end

  assign out_valid_o  = out_valid_q;
  assign current_ma_o = current_q;
  assign changed_o    = changed_q;

endmodule

// ===== hdl/wrms_checker.sv =====
// port-level checker for the windowed rms current meter and its bind
module wrms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            window_end_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [wrms_pkg::MA_W-1:0]       current_ma_o,
  input logic                            changed_o
);

  // one sample at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  // a plain sample never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !window_end_i) |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result without window_end");

  // a new result is loaded only while the input side is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(current_ma_o) && $stable(changed_o)))
    else $error("stalled result beat changed");

endmodule

bind windowed_rms_current_meter wrms_checker u_wrms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .window_end_i (window_end_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .current_ma_o (current_ma_o),
  .changed_o    (changed_o)
);

// ===== tb/sv/tb_windowed_rms_current_meter.sv =====
// self-checking testbench for windowed_rms_current_meter: directed and random windows
`timescale 1ns / 100ps

module tb_windowed_rms_current_meter;

  localparam int unsigned MV_W       = wrms_pkg::MV_W;
  localparam int unsigned ADC_W      = wrms_pkg::ADC_W;
  localparam int unsigned MPA_W      = wrms_pkg::MPA_W;
  localparam int unsigned MA_W       = wrms_pkg::MA_W;
  localparam int unsigned SUM_W      = wrms_pkg::SUM_W;
  localparam int unsigned ROOT_W     = wrms_pkg::ROOT_W;
  localparam int unsigned CFG_IDX_W  = wrms_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = wrms_pkg::CFG_DATA_W;

  localparam int unsigned MAX_SAMPLES      = 4096;
  localparam int unsigned SETTLE_CYCLES    = 200;
  localparam int unsigned CYCLE_LIMIT      = 800000;
  localparam int unsigned RANDOM_PER_PHASE = 180;
  localparam int unsigned PRINT_LIMIT      = 100;

  typedef struct packed {
    logic [MA_W-1:0] current_ma;
    logic            changed;
  } reading_t;

  typedef struct packed {
    logic [MV_W-1:0]  zero_point;
    logic [MV_W-1:0]  band_low;
    logic [MV_W-1:0]  band_high;
    logic [MPA_W-1:0] mv_per_amp;
    logic [MA_W-1:0]  floor_ma;
    logic [MA_W-1:0]  change_ma;
  } meter_cfg_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_STALLS
  } sink_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ADC_W-1:0]      adc_mv_i;
  logic                  window_end_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [MA_W-1:0]       current_ma_o;
  logic                  changed_o;

  meter_cfg_t      meter_cfg;
  logic [SUM_W-1:0] win_square_sum;
  int unsigned     win_sample_count;
  logic [MA_W-1:0] prev_current_ma;
  reading_t        expected_readings[$];
  reading_t        head_reading;
  int unsigned     mismatches;
  int unsigned     cycle_count;
  int unsigned     burst_left;

  windowed_rms_current_meter #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .adc_mv_i    (adc_mv_i),
    .window_end_i(window_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .current_ma_o(current_ma_o),
    .changed_o   (changed_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic meter_cfg_t make_cfg(input int zp, input int lo, input int hi,
                                          input int mpa, input int fl, input int ch);
    meter_cfg_t c;
    c.zero_point = MV_W'(zp);
    c.band_low   = MV_W'(lo);
    c.band_high  = MV_W'(hi);
    c.mv_per_amp = MPA_W'(mpa);
    c.floor_ma   = MA_W'(fl);
    c.change_ma  = MA_W'(ch);
    return c;
  endfunction

  function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (ROOT_W'(1) << b);
      if (SUM_W'(t) * SUM_W'(t) <= v) r = t;
    end
    return r;
  endfunction

  task automatic predict_reading(input logic [ADC_W-1:0] adc, input logic wend);
    logic [MV_W-1:0]   volt;
    logic [MV_W-1:0]   dev;
    logic [SUM_W:0]    acc;
    logic [SUM_W-1:0]  mean;
    logic [ROOT_W-1:0] root;
    logic [31:0]       sens;
    logic [31:0]       ma;
    logic [MA_W-1:0]   cur;
    logic [MA_W-1:0]   diff;
    int unsigned       n;
    reading_t          r;
    volt = {adc, 1'b0};
    if (win_sample_count < MAX_SAMPLES) begin
      dev = (volt >= meter_cfg.zero_point) ? volt - meter_cfg.zero_point
                                           : meter_cfg.zero_point - volt;
      acc = {1'b0, win_square_sum};
      if (dev > meter_cfg.band_low && dev < meter_cfg.band_high)
        acc = acc + (SUM_W+1)'(dev) * (SUM_W+1)'(dev);
      win_square_sum = acc[SUM_W] ? wrms_pkg::SUM_MAX : acc[SUM_W-1:0];
      win_sample_count++;
    end
    if (wend) begin
      n = (win_sample_count == 0) ? 1 : win_sample_count;
      mean = win_square_sum / SUM_W'(n);
      root = floor_root(mean);
      sens = (meter_cfg.mv_per_amp == '0) ? 32'd1 : 32'(meter_cfg.mv_per_amp);
      ma = (32'(root) * 32'(wrms_pkg::MA_PER_A)) / sens;
      cur = (ma > 32'(wrms_pkg::MA_MAX)) ? wrms_pkg::MA_MAX : ma[MA_W-1:0];
      if (cur < meter_cfg.floor_ma) cur = '0;
      diff = (cur >= prev_current_ma) ? cur - prev_current_ma : prev_current_ma - cur;
      r.current_ma = cur;
      r.changed = (diff > meter_cfg.change_ma);
      expected_readings.push_back(r);
      prev_current_ma = cur;
      win_square_sum = '0;
      win_sample_count = 0;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_reading(adc_mv_i, window_end_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected beat", 32'(current_ma_o), 32'd0);
      end else begin
        head_reading = expected_readings.pop_front();
        if (current_ma_o !== head_reading.current_ma)
          report_mismatch("current_ma", 32'(current_ma_o), 32'(head_reading.current_ma));
        if (changed_o !== head_reading.changed)
          report_mismatch("changed", 32'(changed_o), 32'(head_reading.changed));
      end
    end
  end

  initial begin : sink_pattern
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    logic        level;
    mode = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    level = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(100, 400);
      end
      mode_left--;
      case (mode)
        READY_ALWAYS: begin
          out_ready_i <= 1'b1;
        end
        READY_RANDOM: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (hold_left == 0) begin
            level = !level;
            hold_left = level ? $urandom_range(1, 5) : $urandom_range(1, 40);
          end
          hold_left--;
          out_ready_i <= level;
        end
      endcase
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_sample(input logic [ADC_W-1:0] adc, input logic wend);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    adc_mv_i     <= adc;
    window_end_i <= wend;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input wrms_pkg::cfg_idx_e idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input meter_cfg_t c);
    write_reg(wrms_pkg::CFG_ZERO_POINT, CFG_DATA_W'(c.zero_point));
    write_reg(wrms_pkg::CFG_BAND_LOW, CFG_DATA_W'(c.band_low));
    write_reg(wrms_pkg::CFG_BAND_HIGH, CFG_DATA_W'(c.band_high));
    write_reg(wrms_pkg::CFG_MV_PER_AMP, CFG_DATA_W'(c.mv_per_amp));
    write_reg(wrms_pkg::CFG_FLOOR, CFG_DATA_W'(c.floor_ma));
    write_reg(wrms_pkg::CFG_CHANGE, CFG_DATA_W'(c.change_ma));
    cfg_we_i <= 1'b0;
    meter_cfg = c;
  endtask

  function automatic meter_cfg_t rand_config();
    int zp;
    int lo;
    int hi;
    int t;
    zp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1500, 3500);
    lo = $urandom_range(0, 600);
    hi = lo + $urandom_range(0, 3000);
    if ($urandom_range(0, 7) == 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    return make_cfg(zp, lo, hi, $urandom_range(1, 1000),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 3000),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 3000));
  endfunction

  function automatic logic [ADC_W-1:0] pick_adc();
    int lo;
    int d;
    int volt;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return ADC_W'($urandom_range(0, 4095));
      default: begin
        lo = (meter_cfg.band_low > 2) ? int'(meter_cfg.band_low) - 2 : 0;
        d = $urandom_range(lo, int'(meter_cfg.band_high) + 2);
        volt = $urandom_range(0, 1) ? int'(meter_cfg.zero_point) + d
                                    : int'(meter_cfg.zero_point) - d;
        if (volt < 0) volt = 0;
        if (volt > 8190) volt = 8190;
        return ADC_W'(volt / 2);
      end
    endcase
  endfunction

  task automatic test_default_window();
    send_sample(ADC_W'(1250), 1'b0);
    send_sample(ADC_W'(0), 1'b0);
    send_sample(ADC_W'(4095), 1'b0);
    send_sample(ADC_W'(1600), 1'b1);
    send_sample(ADC_W'(1250), 1'b1);
  endtask

  task automatic test_band_edges();
    settle_idle();
    set_config(make_cfg(2000, 100, 200, 185, 0, 0));
    send_sample(ADC_W'(1050), 1'b0);
    send_sample(ADC_W'(1051), 1'b0);
    send_sample(ADC_W'(949), 1'b0);
    send_sample(ADC_W'(1100), 1'b0);
    send_sample(ADC_W'(1099), 1'b0);
    send_sample(ADC_W'(900), 1'b1);
    send_sample(ADC_W'(1000), 1'b1);
  endtask

  task automatic test_sensitivity_and_floor();
    settle_idle();
    set_config(make_cfg(0, 0, 8191, 0, 0, 65535));
    send_sample(ADC_W'(4095), 1'b1);
    settle_idle();
    set_config(make_cfg(0, 0, 8191, 1, 0, 65535));
    send_sample(ADC_W'(1), 1'b1);
    send_sample(ADC_W'(4095), 1'b1);
    settle_idle();
    set_config(make_cfg(8191, 8191, 8191, 1000, 65535, 65535));
    send_sample(ADC_W'(0), 1'b1);
    settle_idle();
    set_config(make_cfg(0, 0, 8191, 1000, 65535, 0));
    send_sample(ADC_W'(100), 1'b1);
    send_sample(ADC_W'(4095), 1'b1);
  endtask

  task automatic test_inverted_band();
    settle_idle();
    set_config(make_cfg(2500, 1000, 500, 185, 0, 0));
    send_sample(ADC_W'(1600), 1'b0);
    send_sample(ADC_W'(1000), 1'b0);
    send_sample(ADC_W'(2000), 1'b1);
  endtask

  task automatic test_random_traffic();
    meter_cfg_t  c;
    int unsigned window_left;
    for (int p = 0; p < 6; p++) begin
      settle_idle();
      case (p)
        0: c = make_cfg(wrms_pkg::RST_ZERO_POINT, wrms_pkg::RST_BAND_LOW,
                        wrms_pkg::RST_BAND_HIGH, wrms_pkg::RST_MV_PER_AMP,
                        wrms_pkg::RST_FLOOR, wrms_pkg::RST_CHANGE);
        1: c = make_cfg(0, 0, 0, 0, 0, 0);
        2: c = make_cfg(8191, 0, 8191, 1000, 0, 65535);
        default: c = rand_config();
      endcase
      set_config(c);
      window_left = 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 3 && i == RANDOM_PER_PHASE / 2) settle_idle();
        if (window_left == 0)
          window_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                    : $urandom_range(1, 24);
        send_sample(pick_adc(), (window_left == 1) || (i == RANDOM_PER_PHASE - 1));
        window_left--;
      end
    end
  endtask

  initial begin
    meter_cfg = make_cfg(wrms_pkg::RST_ZERO_POINT, wrms_pkg::RST_BAND_LOW,
                         wrms_pkg::RST_BAND_HIGH, wrms_pkg::RST_MV_PER_AMP,
                         wrms_pkg::RST_FLOOR, wrms_pkg::RST_CHANGE);
    win_square_sum = '0;
    win_sample_count = 0;
    prev_current_ma = '0;
    mismatches = 0;
    burst_left = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= wrms_pkg::CFG_ZERO_POINT;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    adc_mv_i     <= '0;
    window_end_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_band_edges();
    test_sensitivity_and_floor();
    test_inverted_band();
    test_random_traffic();
    settle_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wrms_pkg.sv
hdl/wrms_div.sv
hdl/wrms_sqrt.sv
hdl/windowed_rms_current_meter.sv
hdl/wrms_checker.sv
tb/sv/tb_windowed_rms_current_meter.sv
